/* sv/rrts_pkg.sv */
`default_nettype none
package rrts_pkg;

  localparam int MAX_TASKS_DEF    = 16;
  localparam int HANDLE_WIDTH_DEF = 16;

  localparam logic [2:0] ACT_YIELD    = 3'd0;
  localparam logic [2:0] ACT_SLEEP_RD = 3'd1;
  localparam logic [2:0] ACT_SLEEP_WR = 3'd2;
  localparam logic [2:0] ACT_FINISH   = 3'd3;
  localparam logic [2:0] ACT_SPAWN    = 3'd4;
  localparam logic [2:0] ACT_WAKE     = 3'd5;
  localparam logic [2:0] ACT_POLL     = 3'd6;
  localparam logic [2:0] ACT_NOP      = 3'd7;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_EMPTY        = 3'd1;
  localparam logic [2:0] ST_MAIN_FINISH  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd3;
  localparam logic [2:0] ST_NOT_SLEEPING = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] handle;
    logic [3:0]  wake_id;
    logic [15:0] ready_mask;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] running_id;
    logic [3:0] new_id;
    logic [3:0] slot_index;
    logic [4:0] active_count;
    logic [4:0] sleeping_count;
  } out_t;

endpackage
`default_nettype wire

/* sv/round_robin_task_scheduler_top.sv */
// the sleeper scan checks one slot a cycle while no slot matches ready_mask; a woken sleeper
// passes through S_MW1 and S_MW2, and a wake by id checks each slot in S_WAKE_SCAN and S_WAKE_CHK
// one item at a time; the next start can be taken in the out_strobe cycle
// results show for one cycle on out_strobe; the receiver cannot stall
// reset: synchronous active low; after reset the S_INIT state writes task 0 into the active list
`default_nettype none
module round_robin_task_scheduler_top #(
  parameter int MAX_TASKS    = rrts_pkg::MAX_TASKS_DEF,
  parameter int HANDLE_WIDTH = rrts_pkg::HANDLE_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire rrts_pkg::in_t in_data,
  output logic               out_strobe,
  output rrts_pkg::out_t     out_data
);

  localparam int IDW  = $clog2(MAX_TASKS);
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int AW   = IDW + 1;
  localparam int AD   = 2 ** AW;
  localparam int SWD  = IDW + HANDLE_WIDTH;
  localparam logic [CW-1:0] MAXC = CW'(MAX_TASKS);

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_CUR_RD    = 4'd2;
  localparam logic [3:0] S_DROP_RD   = 4'd3;
  localparam logic [3:0] S_MASK_STEP = 4'd4;
  localparam logic [3:0] S_MW1       = 4'd5;
  localparam logic [3:0] S_MW2       = 4'd6;
  localparam logic [3:0] S_REDUCE    = 4'd7;
  localparam logic [3:0] S_REPORT    = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;
  localparam logic [3:0] S_SPAWN_RD  = 4'd10;
  localparam logic [3:0] S_WAKE_SCAN = 4'd11;
  localparam logic [3:0] S_WAKE_CHK  = 4'd12;
  localparam logic [3:0] S_WAKE_MV   = 4'd13;

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  act_total_r, act_total_nxt;
  logic [CW-1:0]  cur_r, cur_nxt;
  logic [CW-1:0]  slp_total_r, slp_total_nxt;
  logic [CW-1:0]  free_total_r, free_total_nxt;
  logic [CW-1:0]  fresh_r, fresh_nxt;
  logic [CW-1:0]  scan_r, scan_nxt;
  rrts_pkg::in_t  req_r, req_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [IDW-1:0] new_id_r, new_id_nxt;
  logic [IDW-1:0] slot_r, slot_nxt;
  logic [IDW-1:0] wid_r, wid_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  rrts_pkg::out_t out_r, out_nxt;

  logic           a_we;
  logic [AW-1:0]  a_waddr, a_raddr;
  logic [IDW-1:0] a_wdata, a_rdata;
  logic           s_we;
  logic [IDW-1:0] s_waddr, s_raddr;
  logic [SWD-1:0] s_wdata, s_rdata;

  logic [CW-1:0]            scan_m1;
  logic [CW+3:0]            scan_ext;
  logic                     mask_hit;
  logic [HANDLE_WIDTH+15:0] hnd_ext;
  logic [IDW-1:0]           s_id;
  logic [IDW+3:0]           wake_ext;
  logic [IDW+3:0]           sid_ext;

  function automatic logic [AW-1:0] a_act(input logic [CW-1:0] x);
    return {1'b0, x[IDW-1:0]};
  endfunction

  function automatic logic [AW-1:0] a_free(input logic [CW-1:0] x);
    return {1'b1, x[IDW-1:0]};
  endfunction

  function automatic logic [3:0] ext4(input logic [IDW-1:0] x);
    logic [IDW+3:0] t;
    t = {4'b0, x};
    return t[3:0];
  endfunction

  function automatic logic [4:0] ext5(input logic [CW-1:0] x);
    logic [CW+4:0] t;
    t = {5'b0, x};
    return t[4:0];
  endfunction

  rrts_ram #(.WIDTH(IDW), .DEPTH(AD)) u_act_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  rrts_ram #(.WIDTH(SWD), .DEPTH(MAX_TASKS)) u_slp_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign scan_m1  = scan_r - CW'(1);
  assign scan_ext = {4'b0, scan_m1};
  assign mask_hit = (scan_ext < (CW+4)'(16)) && req_r.ready_mask[scan_ext[3:0]];
  assign hnd_ext  = {{HANDLE_WIDTH{1'b0}}, req_r.handle};
  assign s_id     = s_rdata[SWD-1 -: IDW];
  assign wake_ext = {{IDW{1'b0}}, req_r.wake_id};
  assign sid_ext  = {4'b0, s_id};

  always_comb begin
    state_nxt      = state_r;
    act_total_nxt  = act_total_r;
    cur_nxt        = cur_r;
    slp_total_nxt  = slp_total_r;
    free_total_nxt = free_total_r;
    fresh_nxt      = fresh_r;
    scan_nxt       = scan_r;
    req_nxt        = req_r;
    status_nxt     = status_r;
    new_id_nxt     = new_id_r;
    slot_nxt       = slot_r;
    wid_nxt        = wid_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    a_we           = 1'b0;
    a_waddr        = '0;
    a_wdata        = '0;
    a_raddr        = '0;
    s_we           = 1'b0;
    s_waddr        = '0;
    s_wdata        = '0;
    s_raddr        = '0;

    unique case (state_r)
      S_INIT: begin
        a_we      = 1'b1;
        a_waddr   = a_act('0);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_data;
          status_nxt = rrts_pkg::ST_OK;
          new_id_nxt = '0;
          slot_nxt   = '0;
          scan_nxt   = slp_total_r;
          unique case (in_data.action) inside
            rrts_pkg::ACT_YIELD: begin
              cur_nxt   = cur_r + CW'(1);
              state_nxt = S_MASK_STEP;
            end
            rrts_pkg::ACT_SLEEP_RD, rrts_pkg::ACT_SLEEP_WR: begin
              if (act_total_r != '0 && slp_total_r < MAXC) begin
                a_raddr   = a_act(cur_r);
                state_nxt = S_CUR_RD;
              end else begin
                state_nxt = S_MASK_STEP;
              end
            end
            rrts_pkg::ACT_FINISH: begin
              if (act_total_r != '0) begin
                a_raddr   = a_act(cur_r);
                state_nxt = S_CUR_RD;
              end else begin
                state_nxt = S_MASK_STEP;
              end
            end
            rrts_pkg::ACT_SPAWN: begin
              if (free_total_r != '0) begin
                a_raddr   = a_free(free_total_r - CW'(1));
                state_nxt = S_SPAWN_RD;
              end else if (fresh_r < MAXC) begin
                new_id_nxt = fresh_r[IDW-1:0];
                fresh_nxt  = fresh_r + CW'(1);
                if (act_total_r < MAXC) begin
                  a_we          = 1'b1;
                  a_waddr       = a_act(act_total_r);
                  a_wdata       = fresh_r[IDW-1:0];
                  act_total_nxt = act_total_r + CW'(1);
                end
                state_nxt = S_REPORT;
              end else begin
                status_nxt = rrts_pkg::ST_TABLE_FULL;
                state_nxt  = S_REPORT;
              end
            end
            rrts_pkg::ACT_WAKE: begin
              scan_nxt  = '0;
              state_nxt = S_WAKE_SCAN;
            end
            rrts_pkg::ACT_POLL: begin
              state_nxt = S_MASK_STEP;
            end
            default: begin
              state_nxt = S_REPORT;
            end
          endcase
        end
      end
      S_CUR_RD: begin
        if (req_r.action == rrts_pkg::ACT_FINISH) begin
          if (a_rdata == '0) begin
            status_nxt = rrts_pkg::ST_MAIN_FINISH;
            state_nxt  = S_REPORT;
          end else begin
            if (free_total_r < MAXC) begin
              a_we           = 1'b1;
              a_waddr        = a_free(free_total_r);
              a_wdata        = a_rdata;
              free_total_nxt = free_total_r + CW'(1);
            end
            a_raddr   = a_act(act_total_r - CW'(1));
            state_nxt = S_DROP_RD;
          end
        end else begin
          s_we          = 1'b1;
          s_waddr       = slp_total_r[IDW-1:0];
          s_wdata       = {a_rdata, hnd_ext[HANDLE_WIDTH-1:0]};
          slot_nxt      = slp_total_r[IDW-1:0];
          slp_total_nxt = slp_total_r + CW'(1);
          a_raddr       = a_act(act_total_r - CW'(1));
          state_nxt     = S_DROP_RD;
        end
      end
      S_DROP_RD: begin
        a_we          = 1'b1;
        a_waddr       = a_act(cur_r);
        a_wdata       = a_rdata;
        act_total_nxt = act_total_r - CW'(1);
        scan_nxt      = slp_total_r;
        state_nxt     = S_MASK_STEP;
      end
      S_MASK_STEP: begin
        if (scan_r == '0) begin
          state_nxt = S_REDUCE;
        end else begin
          scan_nxt = scan_m1;
          if (mask_hit) begin
            s_raddr   = scan_m1[IDW-1:0];
            state_nxt = S_MW1;
          end
        end
      end
      S_MW1: begin
        wid_nxt   = s_id;
        s_raddr   = slp_total_r[IDW-1:0] - IDW'(1);
        state_nxt = S_MW2;
      end
      S_MW2: begin
        s_we          = 1'b1;
        s_waddr       = scan_r[IDW-1:0];
        s_wdata       = s_rdata;
        slp_total_nxt = slp_total_r - CW'(1);
        if (act_total_r < MAXC) begin
          a_we          = 1'b1;
          a_waddr       = a_act(act_total_r);
          a_wdata       = wid_r;
          act_total_nxt = act_total_r + CW'(1);
        end
        state_nxt = S_MASK_STEP;
      end
      S_REDUCE: begin
        if (act_total_r == '0) begin
          cur_nxt = '0;
        end else if (cur_r >= act_total_r) begin
          cur_nxt = cur_r - act_total_r;
        end
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        a_raddr   = a_act(cur_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_strobe_nxt = 1'b1;
        out_nxt.status = (status_r == rrts_pkg::ST_OK && act_total_r == '0) ?
                         rrts_pkg::ST_EMPTY : status_r;
        out_nxt.running_id     = (act_total_r != '0) ? ext4(a_rdata) : 4'd0;
        out_nxt.new_id         = ext4(new_id_r);
        out_nxt.slot_index     = ext4(slot_r);
        out_nxt.active_count   = ext5(act_total_r);
        out_nxt.sleeping_count = ext5(slp_total_r);
        state_nxt              = S_IDLE;
      end
      S_SPAWN_RD: begin
        new_id_nxt     = a_rdata;
        free_total_nxt = free_total_r - CW'(1);
        if (act_total_r < MAXC) begin
          a_we          = 1'b1;
          a_waddr       = a_act(act_total_r);
          a_wdata       = a_rdata;
          act_total_nxt = act_total_r + CW'(1);
        end
        state_nxt = S_REPORT;
      end
      S_WAKE_SCAN: begin
        if (scan_r >= slp_total_r) begin
          status_nxt = rrts_pkg::ST_NOT_SLEEPING;
          state_nxt  = S_REPORT;
        end else begin
          s_raddr   = scan_r[IDW-1:0];
          state_nxt = S_WAKE_CHK;
        end
      end
      S_WAKE_CHK: begin
        if (sid_ext == wake_ext) begin
          wid_nxt   = s_id;
          s_raddr   = slp_total_r[IDW-1:0] - IDW'(1);
          state_nxt = S_WAKE_MV;
        end else begin
          scan_nxt  = scan_r + CW'(1);
          state_nxt = S_WAKE_SCAN;
        end
      end
      S_WAKE_MV: begin
        s_we          = 1'b1;
        s_waddr       = scan_r[IDW-1:0];
        s_wdata       = s_rdata;
        slp_total_nxt = slp_total_r - CW'(1);
        if (act_total_r < MAXC) begin
          a_we          = 1'b1;
          a_waddr       = a_act(act_total_r);
          a_wdata       = wid_r;
          act_total_nxt = act_total_r + CW'(1);
        end
        state_nxt = S_REPORT;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      act_total_r  <= CW'(1);
      cur_r        <= '0;
      slp_total_r  <= '0;
      free_total_r <= '0;
      fresh_r      <= CW'(1);
      scan_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      act_total_r  <= act_total_nxt;
      cur_r        <= cur_nxt;
      slp_total_r  <= slp_total_nxt;
      free_total_r <= free_total_nxt;
      fresh_r      <= fresh_nxt;
      scan_r       <= scan_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    status_r <= status_nxt;
    new_id_r <= new_id_nxt;
    slot_r   <= slot_nxt;
    wid_r    <= wid_nxt;
    out_r    <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_OUT && !busy))
    else $error("result strobe outside report sequence");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      (cur_r < act_total_r || (act_total_r == '0 && cur_r == '0)))
    else $error("current index out of range while idle");

  a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (act_total_r <= MAXC) && (slp_total_r <= MAXC) && (free_total_r <= MAXC))
    else $error("list count beyond capacity");
`endif

endmodule
`default_nettype wire

/* sv/rrts_ram.sv */
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
